@@ rtl/core/shmb_pkg.sv @@
package shmb_pkg;

	// parse phases of the slice header walk
	localparam logic [3:0] PH_POS   = 4'd0;
	localparam logic [3:0] PH_EXT   = 4'd1;
	localparam logic [3:0] PH_QS    = 4'd2;
	localparam logic [3:0] PH_FLAG  = 4'd3;
	localparam logic [3:0] PH_INTRA = 4'd4;
	localparam logic [3:0] PH_RESV  = 4'd5;
	localparam logic [3:0] PH_EXTRA = 4'd6;
	localparam logic [3:0] PH_SKIP  = 4'd7;
	localparam logic [3:0] PH_VLC   = 4'd8;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_EXTRA = 2'd1;
	localparam logic [1:0] ST_TRUNC     = 2'd2;
	localparam logic [1:0] ST_BAD_CODE  = 2'd3;

	localparam logic [13:0] HEIGHT_LIMIT = 14'd2800;
	localparam logic [12:0] ESCAPE_ADD   = 13'd33;
	localparam logic [12:0] COL_SAT      = 13'd4096;
	localparam logic [15:0] HDR_SAT      = 16'hFFFF;
	localparam int          VLC_COUNT    = 34;

	// macroblock address increment codes, increment 0 marks the escape
	localparam logic [3:0] VLC_LEN [VLC_COUNT] = '{
		4'd1, 4'd3, 4'd3, 4'd4, 4'd4, 4'd5, 4'd5, 4'd7, 4'd7, 4'd8,
		4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
		4'd10, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11,
		4'd11, 4'd11, 4'd11, 4'd11
	};
	localparam logic [10:0] VLC_CODE [VLC_COUNT] = '{
		11'h001, 11'h003, 11'h002, 11'h003, 11'h002, 11'h003, 11'h002, 11'h007,
		11'h006, 11'h00b, 11'h00a, 11'h009, 11'h008, 11'h007, 11'h006, 11'h017,
		11'h016, 11'h015, 11'h014, 11'h013, 11'h012, 11'h023, 11'h022, 11'h021,
		11'h020, 11'h01f, 11'h01e, 11'h01d, 11'h01c, 11'h01b, 11'h01a, 11'h019,
		11'h018, 11'h008
	};
	localparam logic [5:0] VLC_INC [VLC_COUNT] = '{
		6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10,
		6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20,
		6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30,
		6'd31, 6'd32, 6'd33, 6'd0
	};

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} shmb_entry_t;

	typedef struct packed {
		logic        valid;
		shmb_entry_t entry;
	} shmb_qhead_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] len;
		logic [5:0] inc;
	} shmb_vlc_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] header_bits;
		logic        intra_slice_bit;
		logic        intra_flag_present;
		logic [4:0]  quant_scale_code;
		logic [11:0] mb_column;
		logic [10:0] mb_row;
	} shmb_result_t;

	// codes are prefix free, so at most one entry matches
	function automatic shmb_vlc_t shmb_decode(input logic [10:0] bits, input logic [4:0] avail);
		shmb_vlc_t r;
		r = '0;
		for (int i = 0; i < VLC_COUNT; i++) begin
			if (({1'b0, VLC_LEN[i]} <= avail) &&
			    ((bits >> (4'd11 - VLC_LEN[i])) == VLC_CODE[i])) begin
				r.hit = 1'b1;
				r.len = VLC_LEN[i];
				r.inc = VLC_INC[i];
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/core/shmb_front.sv @@
module shmb_front #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,
	input  logic                  s_tlast,
	output shmb_pkg::shmb_qhead_t head,
	input  logic                  pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	shmb_pkg::shmb_entry_t slot_q [DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [CW-1:0]         fill_q;
	logic                  push;

	assign s_tready = (fill_q != CW'(DEPTH));
	assign push     = s_tvalid && s_tready;

	assign head.valid = (fill_q != '0);
	assign head.entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{data: s_tdata, last: s_tlast};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: fill_q <= fill_q + 1'b1;
				2'b01: fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ rtl/core/shmb_back.sv @@
module shmb_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [13:0]            cfg_wdata,
	input  shmb_pkg::shmb_qhead_t  head,
	output logic                   pop,
	output logic                   res_valid,
	input  logic                   res_ready,
	output shmb_pkg::shmb_result_t res
);

	logic [13:0] height_q;
	logic [3:0]  phase_q, phase_d;
	logic [23:0] win_q, win_d;
	logic [4:0]  cnt_q, cnt_d;
	logic [10:0] row_q, row_d;
	logic [12:0] col_q, col_d;
	logic [15:0] pos_q, pos_d;
	logic [6:0]  latch_q, latch_d;
	logic        sent_q, sent_d;
	logic        lastp_q, lastp_d;
	logic        out_valid_q;
	shmb_pkg::shmb_result_t out_q, res_d;
	logic        out_load;

	logic [23:0] al;
	logic [3:0]  need;
	shmb_pkg::shmb_vlc_t vlc;
	logic        is_vlc;
	logic        step_ok;
	logic        step_emit;
	logic        out_free;
	logic [13:0] col_sum;
	logic [12:0] col_new;
	logic [16:0] pos_sum;
	logic [15:0] pos_new;
	logic [5:0]  cnt_sum;
	logic        do_clear;

	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		// unread bits moved up to the top of the window
		al = win_q << (5'd24 - cnt_q);
		case (phase_q)
			shmb_pkg::PH_POS:   need = 4'd8;
			shmb_pkg::PH_EXT:   need = 4'd3;
			shmb_pkg::PH_QS:    need = 4'd5;
			shmb_pkg::PH_RESV:  need = 4'd7;
			shmb_pkg::PH_SKIP:  need = 4'd8;
			shmb_pkg::PH_VLC:   need = 4'd0;
			default:            need = 4'd1;
		endcase
		vlc       = shmb_pkg::shmb_decode(al[23:13], cnt_q);
		is_vlc    = (phase_q == shmb_pkg::PH_VLC);
		step_ok   = !sent_q && (is_vlc ? (vlc.hit || (cnt_q >= 5'd11))
		                               : (cnt_q >= {1'b0, need}));
		step_emit = is_vlc && (!vlc.hit || (vlc.inc != 6'd0));
		out_free  = !out_valid_q || res_ready;
		col_sum   = {1'b0, col_q} + ((vlc.inc == 6'd0) ? {1'b0, shmb_pkg::ESCAPE_ADD}
		                                               : {8'd0, vlc.inc});
		col_new   = (col_sum > {1'b0, shmb_pkg::COL_SAT}) ? shmb_pkg::COL_SAT : col_sum[12:0];
		pos_sum   = {1'b0, pos_q} + {13'd0, need};
		pos_new   = pos_sum[16] ? shmb_pkg::HDR_SAT : pos_sum[15:0];
		cnt_sum   = {1'b0, cnt_q} + 6'd8;

		phase_d  = phase_q;
		win_d    = win_q;
		cnt_d    = cnt_q;
		row_d    = row_q;
		col_d    = col_q;
		pos_d    = pos_q;
		latch_d  = latch_q;
		sent_d   = sent_q;
		lastp_d  = lastp_q;
		pop      = 1'b0;
		out_load = 1'b0;
		do_clear = 1'b0;

		res_d.mb_row             = row_q;
		res_d.mb_column          = '0;
		res_d.quant_scale_code   = latch_q[4:0];
		res_d.intra_flag_present = latch_q[5];
		res_d.intra_slice_bit    = latch_q[6];
		res_d.header_bits        = is_vlc ? pos_q : '0;
		res_d.status             = shmb_pkg::ST_TRUNC;

		if (step_ok) begin
			if (!(step_emit && !out_free)) begin
				if (!is_vlc) begin
					cnt_d = cnt_q - {1'b0, need};
					pos_d = pos_new;
				end
				case (phase_q)
					shmb_pkg::PH_POS: begin
						row_d   = {3'b000, al[23:16]} - 11'd1;
						phase_d = (height_q > shmb_pkg::HEIGHT_LIMIT) ? shmb_pkg::PH_EXT
						                                            : shmb_pkg::PH_QS;
					end
					shmb_pkg::PH_EXT: begin
						row_d   = row_q + {1'b0, al[23:21], 7'd0};
						phase_d = shmb_pkg::PH_QS;
					end
					shmb_pkg::PH_QS: begin
						latch_d = {2'b00, al[23:19]};
						phase_d = shmb_pkg::PH_FLAG;
					end
					shmb_pkg::PH_FLAG: begin
						if (al[23]) begin
							latch_d[5] = 1'b1;
							phase_d    = shmb_pkg::PH_INTRA;
						end else begin
							phase_d = shmb_pkg::PH_VLC;
						end
					end
					shmb_pkg::PH_INTRA: begin
						latch_d[6] = al[23];
						phase_d    = shmb_pkg::PH_RESV;
					end
					shmb_pkg::PH_RESV: begin
						phase_d = shmb_pkg::PH_EXTRA;
					end
					shmb_pkg::PH_EXTRA: begin
						phase_d = al[23] ? shmb_pkg::PH_SKIP : shmb_pkg::PH_VLC;
					end
					shmb_pkg::PH_SKIP: begin
						phase_d = shmb_pkg::PH_EXTRA;
					end
					shmb_pkg::PH_VLC: begin
						if (!vlc.hit) begin
							res_d.status = shmb_pkg::ST_BAD_CODE;
							out_load     = 1'b1;
							sent_d       = 1'b1;
						end else begin
							cnt_d = cnt_q - {1'b0, vlc.len};
							col_d = col_new;
							if (vlc.inc != 6'd0) begin
								res_d.status    = shmb_pkg::ST_OK;
								res_d.mb_column = 12'(col_new - 13'd1);
								out_load        = 1'b1;
								sent_d          = 1'b1;
							end
						end
					end
					default: begin
						phase_d = shmb_pkg::PH_POS;
					end
				endcase
			end
		end else if (lastp_q) begin
			if (sent_q) begin
				do_clear = 1'b1;
			end else if (out_free) begin
				out_load = 1'b1;
				do_clear = 1'b1;
			end
		end else if (head.valid) begin
			pop = 1'b1;
			if (sent_q) begin
				do_clear = head.entry.last;
			end else begin
				win_d   = {win_q[15:0], head.entry.data};
				cnt_d   = (cnt_sum > 6'd24) ? 5'd24 : cnt_sum[4:0];
				lastp_d = head.entry.last;
			end
		end

		if (do_clear) begin
			phase_d = shmb_pkg::PH_POS;
			win_d   = '0;
			cnt_d   = '0;
			row_d   = '0;
			col_d   = '0;
			pos_d   = '0;
			latch_d = '0;
			sent_d  = 1'b0;
			lastp_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q    <= '0;
			phase_q     <= shmb_pkg::PH_POS;
			win_q       <= '0;
			cnt_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			pos_q       <= '0;
			latch_q     <= '0;
			sent_q      <= 1'b0;
			lastp_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				height_q <= cfg_wdata;
			end
			phase_q <= phase_d;
			win_q   <= win_d;
			cnt_q   <= cnt_d;
			row_q   <= row_d;
			col_q   <= col_d;
			pos_q   <= pos_d;
			latch_q <= latch_d;
			sent_q  <= sent_d;
			lastp_q <= lastp_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/slice_header_mb_position_decoder.sv @@
// flow: a request waits in the byte queue, is loaded into the bit window and is parsed one
//   header field or increment code at a time; the result is registered
// pacing: the parser pops the next byte only once no field or code can be completed from the
//   window, and drops bytes after the unit's result is out; a truncated unit emits its result
//   once its last byte is loaded and nothing more completes, the queue absorbs bursts
// reset: arst_n clears the queue, the parse state, the result valid flag and picture_height
module slice_header_mb_position_decoder #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream of one slice unit
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	// picture height register
	input  logic        cfg_wen,
	input  logic [13:0] cfg_wdata, // picture_height
	// one result per unit
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [10:0] mb_row, [22:11] mb_column,
	                               // [27:23] quant_scale_code, [28] intra_flag_present,
	                               // [29] intra_slice_bit, [45:30] header_bits, [47:46] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	shmb_pkg::shmb_qhead_t  head;
	logic                   pop;
	shmb_pkg::shmb_result_t res;

	// front: takes requests and tags the unit's final byte, queued for the parser
	shmb_front #(
		.DEPTH (FIFO_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.head     (head),
		.pop      (pop)
	);

	// back: bit window parser, one field or code per cycle when not stalled, output register
	shmb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.pop       (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// pack the result, first field lowest
	assign m_tdata = {2'b00, res.header_bits, res.intra_slice_bit, res.intra_flag_present,
	                  res.quant_scale_code, res.mb_column, res.mb_row};
	assign m_tuser = res.status;

endmodule

@@ rtl/core/shmb_checker.sv @@
module shmb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a result waiting for the sink holds still
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// the bad extra-information status is never reported
	a_no_bad_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != shmb_pkg::ST_BAD_EXTRA)
		else $error("bad extra bit status seen");

	// column is only reported for a good slice
	a_col_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != shmb_pkg::ST_OK) |-> m_tdata[22:11] == 12'd0)
		else $error("column set on error result");

	// a result from the increment codes, good or bad, means the shortest header had been read
	a_header_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tuser == shmb_pkg::ST_OK) || (m_tuser == shmb_pkg::ST_BAD_CODE))
		|-> m_tdata[45:30] >= 16'd14)
		else $error("header length too short");

	// intra slice bit only exists behind the flag
	a_intra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[29] |-> m_tdata[28])
		else $error("intra bit without flag");

endmodule

bind slice_header_mb_position_decoder shmb_checker u_shmb_checker (.*);

@@ tb/slice_header_mb_position_decoder_tb.sv @@
module slice_header_mb_position_decoder_tb;

	// one request on the byte side
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} slice_byte_t;

	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE      = 40;
	localparam int ESC_IDX     = 33;

	// table b-1 in order of increment 1 to 33, the escape last
	localparam int CODE_LEN [34] = '{
		1, 3, 3, 4, 4, 5, 5, 7, 7, 8, 8, 8, 8, 8, 8, 10, 10, 10, 10, 10, 10,
		11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11, 11
	};
	localparam int CODE_VAL [34] = '{
		'h1, 'h3, 'h2, 'h3, 'h2, 'h3, 'h2, 'h7, 'h6, 'hb, 'ha, 'h9, 'h8, 'h7, 'h6,
		'h17, 'h16, 'h15, 'h14, 'h13, 'h12, 'h23, 'h22, 'h21, 'h20, 'h1f, 'h1e,
		'h1d, 'h1c, 'h1b, 'h1a, 'h19, 'h18, 'h08
	};

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        s_tlast   = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic [13:0] cfg_wdata = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	// stimulus side
	slice_byte_t  slice_bytes[$];
	bit           slice_bits[$];
	int           queued   = 0;
	int           accepted = 0;
	int           send_gap = 0;
	int           rx_wait  = 0;
	bit           idle_on    = 1'b1;
	bit           hold_start = 1'b0;
	bit           rx_block   = 1'b0;

	// checking side
	shmb_pkg::shmb_result_t expected_headers[$];
	int                     header_mismatches = 0;

	// predictor state, all clear after reset
	logic [13:0]  pic_height = '0;
	logic [3:0]   ph         = shmb_pkg::PH_POS;
	logic [23:0]  win        = '0;
	int unsigned  wcnt       = 0;
	logic [10:0]  row_acc    = '0;
	int unsigned  col_acc    = 0;
	int unsigned  hdr_pos    = 0;
	logic [7:0]   fields     = '0;
	bit           done       = 1'b0;

	slice_header_mb_position_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void clear_slice();
		ph      = shmb_pkg::PH_POS;
		win     = '0;
		wcnt    = 0;
		row_acc = '0;
		col_acc = 0;
		hdr_pos = 0;
		fields  = '0;
		done    = 1'b0;
	endfunction

	// msb-first view of the unread bits
	function automatic int unsigned peek_bits(int unsigned n);
		return (32'(win) >> (wcnt - n)) & ((32'd1 << n) - 1);
	endfunction

	// header bits are counted until the increment codes start, then frozen
	function automatic int unsigned take_bits(int unsigned n);
		int unsigned v;
		v = peek_bits(n);
		wcnt -= n;
		win &= 24'((32'd1 << wcnt) - 1);
		if (ph != shmb_pkg::PH_VLC) begin
			hdr_pos = (hdr_pos + n > 32'hFFFF) ? 32'hFFFF : hdr_pos + n;
		end
		return v;
	endfunction

	function automatic void post_header(logic [1:0] st);
		shmb_pkg::shmb_result_t r;
		int unsigned            c;
		c = 0;
		if (st == shmb_pkg::ST_OK && col_acc != 0) begin
			c = col_acc - 1;
		end
		if (c > 4095) begin
			c = 4095;
		end
		r.mb_row             = row_acc;
		r.mb_column          = c[11:0];
		r.quant_scale_code   = fields[4:0];
		r.intra_flag_present = fields[5];
		r.intra_slice_bit    = fields[6];
		r.header_bits        = (ph == shmb_pkg::PH_VLC) ? hdr_pos[15:0] : 16'd0;
		r.status             = st;
		expected_headers.push_back(r);
		done = 1'b1;
	endfunction

	// walks the header as far as the buffered bits allow
	function automatic void run_header();
		bit stall;
		int hit;
		stall = 1'b0;
		while (!stall && !done) begin
			case (ph)
				shmb_pkg::PH_POS: begin
					if (wcnt < 8) begin
						stall = 1'b1;
					end else begin
						row_acc = 11'(take_bits(8) - 1);
						ph = (pic_height > shmb_pkg::HEIGHT_LIMIT) ? shmb_pkg::PH_EXT
						                                          : shmb_pkg::PH_QS;
					end
				end
				shmb_pkg::PH_EXT: begin
					if (wcnt < 3) begin
						stall = 1'b1;
					end else begin
						row_acc = row_acc + 11'(take_bits(3) << 7);
						ph = shmb_pkg::PH_QS;
					end
				end
				shmb_pkg::PH_QS: begin
					if (wcnt < 5) begin
						stall = 1'b1;
					end else begin
						fields = 8'(take_bits(5));
						ph = shmb_pkg::PH_FLAG;
					end
				end
				shmb_pkg::PH_FLAG: begin
					if (wcnt < 1) begin
						stall = 1'b1;
					end else if (take_bits(1) != 0) begin
						fields[5] = 1'b1;
						ph = shmb_pkg::PH_INTRA;
					end else begin
						ph = shmb_pkg::PH_VLC;
					end
				end
				shmb_pkg::PH_INTRA: begin
					if (wcnt < 1) begin
						stall = 1'b1;
					end else begin
						fields[6] = take_bits(1) != 0;
						ph = shmb_pkg::PH_RESV;
					end
				end
				shmb_pkg::PH_RESV: begin
					if (wcnt < 7) begin
						stall = 1'b1;
					end else begin
						void'(take_bits(7));
						ph = shmb_pkg::PH_EXTRA;
					end
				end
				shmb_pkg::PH_EXTRA: begin
					if (wcnt < 1) begin
						stall = 1'b1;
					end else begin
						ph = (take_bits(1) != 0) ? shmb_pkg::PH_SKIP : shmb_pkg::PH_VLC;
					end
				end
				shmb_pkg::PH_SKIP: begin
					if (wcnt < 8) begin
						stall = 1'b1;
					end else begin
						void'(take_bits(8));
						ph = shmb_pkg::PH_EXTRA;
					end
				end
				default: begin
					hit = -1;
					for (int i = 0; i < 34; i++) begin
						if (hit < 0 && wcnt >= CODE_LEN[i] &&
						    peek_bits(CODE_LEN[i]) == CODE_VAL[i]) begin
							hit = i;
						end
					end
					if (hit < 0) begin
						// eleven bits and still no code: give up on the unit
						if (wcnt >= 11) begin
							post_header(shmb_pkg::ST_BAD_CODE);
						end else begin
							stall = 1'b1;
						end
					end else begin
						void'(take_bits(CODE_LEN[hit]));
						col_acc += (hit == ESC_IDX) ? shmb_pkg::ESCAPE_ADD : hit + 1;
						if (col_acc > shmb_pkg::COL_SAT) begin
							col_acc = shmb_pkg::COL_SAT;
						end
						if (hit != ESC_IDX) begin
							post_header(shmb_pkg::ST_OK);
						end
					end
				end
			endcase
		end
	endfunction

	// bytes after the result are dropped, the last byte always clears the unit
	function automatic void decode_slice_byte(logic [7:0] d, logic l);
		if (!done) begin
			win  = {win[15:0], d};
			wcnt = (wcnt + 8 > 24) ? 24 : wcnt + 8;
			run_header();
		end
		if (l) begin
			if (!done) begin
				post_header(shmb_pkg::ST_TRUNC);
			end
			clear_slice();
		end
	endfunction

	// ---------------------------------------------------------------- unit builder

	function automatic void put_bits(int unsigned v, int n);
		for (int k = n - 1; k >= 0; k--) begin
			slice_bits.push_back(v[k]);
		end
	endfunction

	// turns the first nbytes of the bit list into requests, last on the final one
	function automatic void flush_bits(int nbytes);
		slice_byte_t e;
		for (int b = 0; b < nbytes; b++) begin
			for (int k = 0; k < 8; k++) begin
				e.data[7 - k] = slice_bits[8 * b + k];
			end
			e.last = (b == nbytes - 1);
			slice_bytes.push_back(e);
			queued++;
		end
		slice_bits.delete();
	endfunction

	function automatic void queue_noise(int nbytes);
		slice_bits.delete();
		put_bits($urandom(), 8 * nbytes);
		flush_bits(nbytes);
	endfunction

	// well formed unit; tail is the final increment, or 0 for a code outside the table;
	// cut ends the unit before the final code is complete
	function automatic void queue_slice(int pos, int ext, int quant, int has_intra,
	                                    int intra_bit, int extra_cnt, int esc_cnt,
	                                    int tail, bit cut, int trail);
		int end_bit;
		int bad;
		int nbytes;
		slice_bits.delete();
		put_bits(pos, 8);
		if (pic_height > shmb_pkg::HEIGHT_LIMIT) begin
			put_bits(ext, 3);
		end
		put_bits(quant, 5);
		put_bits(has_intra, 1);
		if (has_intra != 0) begin
			put_bits(intra_bit, 1);
			put_bits($urandom_range(0, 127), 7);
			repeat (extra_cnt) begin
				put_bits(1, 1);
				put_bits($urandom_range(0, 255), 8);
			end
			put_bits(0, 1);
		end
		repeat (esc_cnt) begin
			put_bits(CODE_VAL[ESC_IDX], CODE_LEN[ESC_IDX]);
		end
		if (tail == 0) begin
			// below 0x018 only the escape is a valid prefix
			bad = $urandom_range(0, 22);
			if (bad >= 8) begin
				bad++;
			end
			put_bits(bad, 11);
		end else begin
			put_bits(CODE_VAL[tail - 1], CODE_LEN[tail - 1]);
		end
		end_bit = slice_bits.size();
		if (cut) begin
			nbytes = $urandom_range(1, (end_bit - 1) / 8);
		end else begin
			while (slice_bits.size() % 8 != 0) begin
				put_bits($urandom_range(0, 1), 1);
			end
			put_bits($urandom(), 8 * trail);
			nbytes = slice_bits.size() / 8;
		end
		flush_bits(nbytes);
	endfunction

	function automatic void queue_random_slice();
		int kind;
		int tail;
		kind = $urandom_range(0, 99);
		if (kind < 15) begin
			queue_noise($urandom_range(1, 8));
		end else begin
			tail = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 7) : $urandom_range(1, 33);
			if (kind < 30) begin
				tail = 0;
			end
			queue_slice($urandom_range(0, 255), $urandom_range(0, 7), $urandom_range(0, 31),
			            $urandom_range(0, 1), $urandom_range(0, 1),
			            ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
			            ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0,
			            tail, kind >= 85, $urandom_range(0, 3));
		end
	endfunction

	// ---------------------------------------------------------------- sender

	// a new request is offered once the current one is taken and its gap has run out
	always @(posedge clk) begin
		slice_byte_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				decode_slice_byte(s_tdata, s_tlast);
				accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					s_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (slice_bytes.size() != 0) begin
					nxt = slice_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.data;
					s_tlast  <= nxt.last;
					send_gap <= idle_on ? $urandom_range(0, 9) : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// stall drawn after every result, plus the long hold-off below
	always @(posedge clk) begin
		int nwait;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				nwait = idle_on ? $urandom_range(0, 9) : 0;
			end else begin
				nwait = (rx_wait > 0) ? rx_wait - 1 : 0;
			end
			rx_wait  <= nwait;
			m_tready <= !rx_block && nwait == 0;
		end
	end

	// long hold-off so the byte queue fills and the input backs up
	initial begin
		while (!hold_start) begin
			@(posedge clk);
		end
		rx_block <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_block <= 1'b0;
	end

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin
		shmb_pkg::shmb_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_headers.size() == 0) begin
				header_mismatches++;
				if (header_mismatches <= 10) begin
					$display("unexpected result: row %0d col %0d qs %0d",
					         m_tdata[10:0], m_tdata[22:11], m_tdata[27:23],
					         " flag %0b intra %0b bits %0d st %0d",
					         m_tdata[28], m_tdata[29], m_tdata[45:30], m_tuser);
				end
			end else begin
				want = expected_headers.pop_front();
				if (m_tdata[10:0] !== want.mb_row || m_tdata[22:11] !== want.mb_column ||
				    m_tdata[27:23] !== want.quant_scale_code ||
				    m_tdata[28] !== want.intra_flag_present ||
				    m_tdata[29] !== want.intra_slice_bit ||
				    m_tdata[45:30] !== want.header_bits || m_tuser !== want.status) begin
					header_mismatches++;
					if (header_mismatches <= 10) begin
						$display("mismatch: expected row %0d col %0d qs %0d",
						         want.mb_row, want.mb_column, want.quant_scale_code,
						         " flag %0b intra %0b bits %0d st %0d",
						         want.intra_flag_present, want.intra_slice_bit,
						         want.header_bits, want.status);
						$display("          actual   row %0d col %0d qs %0d",
						         m_tdata[10:0], m_tdata[22:11], m_tdata[27:23],
						         " flag %0b intra %0b bits %0d st %0d",
						         m_tdata[28], m_tdata[29], m_tdata[45:30], m_tuser);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	// every request taken and every result back, then let ignored bytes drain
	task automatic wait_drained();
		while (accepted != queued || expected_headers.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_height(logic [13:0] h);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_wen    <= 1'b0;
		pic_height = h;
	endtask

	initial begin
		logic [13:0] heights [6];
		int          target;
		heights = '{14'd2800, 14'd2801, 14'($urandom), 14'd16383, 14'd0, 14'($urandom)};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short pictures: no extension bits
		set_height(14'd0);
		queue_slice(0, 0, 31, 0, 0, 0, 0, 1, 1'b0, 0);    // row wraps to the top
		queue_slice(255, 0, 0, 1, 1, 0, 0, 33, 1'b0, 1);  // longest plain code
		queue_slice(1, 0, 17, 1, 0, 1, 1, 1, 1'b0, 0);    // extra byte and one escape
		queue_slice(2, 0, 5, 0, 0, 0, 0, 0, 1'b0, 0);     // code outside the table
		queue_noise(1);                                   // unit ends on its position byte
		queue_slice(9, 0, 12, 1, 1, 0, 0, 20, 1'b1, 0);   // ends before the increment code is complete
		wait_drained();

		// tall pictures: extension bits shift the row
		set_height(14'd16383);
		queue_slice(0, 7, 9, 0, 0, 0, 0, 2, 1'b0, 0);
		queue_slice(128, 0, 31, 1, 1, 0, 0, 7, 1'b0, 0);
		wait_drained();

		// random phases, one of them with no idling on either side
		target = queued;
		for (int p = 0; p < 6; p++) begin
			set_height(heights[p]);
			idle_on <= (p != 2);
			target += 35;
			while (queued < target) begin
				queue_random_slice();
			end
			wait_drained();
		end

		// receiver holds off while the sender keeps offering
		idle_on    <= 1'b0;
		hold_start <= 1'b1;
		repeat (25) queue_random_slice();
		wait_drained();

		// column saturation, then several extra bytes
		idle_on <= 1'b1;
		queue_slice(10, 0, 3, 1, 0, 0, 125, 5, 1'b0, 0);
		queue_slice(20, 5, 8, 1, 1, 3, 0, 1, 1'b0, 2);
		wait_drained();

		if (header_mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// timeout
	initial begin
		#1000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
